// File: src/slcfr_pkg.sv
package slcfr_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h8408;

    localparam logic [7:0] START_BYTE_RST = 8'hAA;
    localparam logic [8:0] MAX_LEN_RST    = 9'd256;
    localparam logic [7:0] TYPE_MASK_RST  = 8'h1F;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_GOOD     = 2'd1,
        KIND_BAD_CRC  = 2'd2,
        KIND_TOO_LONG = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_START_BYTE = 2'd0,
        CFG_MAX_LEN    = 2'd1,
        CFG_TYPE_MASK  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_CMD,
        ST_TYPE,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_PAYLOAD,
        ST_CRC_LO,
        ST_CRC_HI
    } t_state;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [8:0] max_len;
        logic [7:0] type_enable;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [7:0]  command;
        logic [7:0]  message_type;
        logic        type_valid;
        logic [15:0] payload_length;
        logic [15:0] trailer_crc;
        logic [15:0] computed_crc;
    } t_result;

endpackage

// File: src/slcfr_crc8.sv
module slcfr_crc8
    import slcfr_pkg::*;
(
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    always_comb begin
        logic [15:0] v_crc;
        v_crc = i_crc ^ {8'h00, i_byte};
        for (int k = 0; k < 8; k++) begin
            if (v_crc[0]) begin
                v_crc = (v_crc >> 1) ^ CRC_POLY;
            end else begin
                v_crc = v_crc >> 1;
            end
        end
        o_crc = v_crc;
    end

endmodule

// File: src/slcfr_parser.sv
module slcfr_parser
    import slcfr_pkg::*;
#(
    parameter int MAX_PAYLOAD_BYTES = 256
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  t_cfg       i_cfg,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam int LW = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam logic [15:0] MAX16 = 16'(MAX_PAYLOAD_BYTES);

    t_state         r_state, n_state;
    logic [15:0]    r_crc;
    logic [LW-1:0]  r_flen;
    logic [LW-1:0]  r_cnt;
    logic [7:0]     r_cmd;
    logic [7:0]     r_type;
    logic [7:0]     r_len_lo;
    logic [7:0]     r_crc_lo;

    logic [15:0]    w_crc_in;
    logic [15:0]    w_crc_out;
    logic [15:0]    w_length;
    logic [15:0]    w_limit;
    logic           w_too_long;
    logic           w_last_pay;
    logic           w_type_ok;
    logic [15:0]    w_rx_crc;

    assign w_crc_in = (r_state == ST_HUNT) ? CRC_INIT : r_crc;

    slcfr_crc8 u_crc8 (
        .i_crc  (w_crc_in),
        .i_byte (i_data_byte),
        .o_crc  (w_crc_out)
    );

    assign w_length   = {i_data_byte, r_len_lo};
    assign w_limit    = ({7'd0, i_cfg.max_len} > MAX16) ? MAX16 : {7'd0, i_cfg.max_len};
    assign w_too_long = w_length > w_limit;
    assign w_last_pay = ({1'b0, r_cnt} + (LW+1)'(1)) == {1'b0, r_flen};
    assign w_type_ok  = (r_type[7:3] == 5'd0) && i_cfg.type_enable[r_type[2:0]];
    assign w_rx_crc   = {i_data_byte, r_crc_lo};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_HUNT: begin
                if (i_data_byte == i_cfg.start_byte) n_state = ST_CMD;
            end
            ST_CMD:    n_state = ST_TYPE;
            ST_TYPE:   n_state = ST_LEN_LO;
            ST_LEN_LO: n_state = ST_LEN_HI;
            ST_LEN_HI: begin
                if (w_too_long) begin
                    n_state = ST_HUNT;
                end else if (w_length == 16'd0) begin
                    n_state = ST_CRC_LO;
                end else begin
                    n_state = ST_PAYLOAD;
                end
            end
            ST_PAYLOAD: begin
                if (w_last_pay) n_state = ST_CRC_LO;
            end
            ST_CRC_LO: n_state = ST_CRC_HI;
            ST_CRC_HI: n_state = ST_HUNT;
            default:   n_state = ST_HUNT;
        endcase
    end

    always_comb begin
        o_res_valid          = 1'b0;
        o_res.kind           = KIND_PAYLOAD;
        o_res.payload_byte   = 8'd0;
        o_res.payload_index  = 8'd0;
        o_res.command        = r_cmd;
        o_res.message_type   = r_type;
        o_res.type_valid     = w_type_ok;
        o_res.payload_length = 16'(r_flen);
        o_res.trailer_crc    = 16'd0;
        o_res.computed_crc   = 16'd0;
        unique case (r_state)
            ST_LEN_HI: begin
                if (w_too_long) begin
                    o_res_valid          = i_accept;
                    o_res.kind           = KIND_TOO_LONG;
                    o_res.payload_length = w_length;
                end
            end
            ST_PAYLOAD: begin
                o_res_valid         = i_accept;
                o_res.payload_byte  = i_data_byte;
                o_res.payload_index = 8'(r_cnt);
            end
            ST_CRC_HI: begin
                o_res_valid        = i_accept;
                o_res.kind         = (w_rx_crc == r_crc) ? KIND_GOOD : KIND_BAD_CRC;
                o_res.trailer_crc  = w_rx_crc;
                o_res.computed_crc = r_crc;
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
            r_crc   <= CRC_INIT;
            r_flen  <= '0;
            r_cnt   <= '0;
        end else if (i_accept) begin
            r_state <= n_state;
            unique case (r_state)
                ST_HUNT, ST_CMD, ST_TYPE, ST_LEN_LO, ST_PAYLOAD: begin
                    if (r_state != ST_HUNT || n_state == ST_CMD) r_crc <= w_crc_out;
                end
                ST_LEN_HI: begin
                    if (w_too_long) begin
                        r_crc <= CRC_INIT;
                    end else begin
                        r_crc  <= w_crc_out;
                        r_flen <= LW'(w_length);
                    end
                end
                ST_CRC_LO: r_crc <= r_crc;
                ST_CRC_HI: r_crc <= CRC_INIT;
                default:   r_crc <= CRC_INIT;
            endcase
            if (r_state == ST_LEN_HI) begin
                r_cnt <= '0;
            end else if (r_state == ST_PAYLOAD) begin
                r_cnt <= r_cnt + LW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            if (r_state == ST_CMD)    r_cmd    <= i_data_byte;
            if (r_state == ST_TYPE)   r_type   <= i_data_byte;
            if (r_state == ST_LEN_LO) r_len_lo <= i_data_byte;
            if (r_state == ST_CRC_LO) r_crc_lo <= i_data_byte;
        end
    end

endmodule

// File: src/slcfr_out_reg.sv
module slcfr_out_reg
    import slcfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_valid,
    output logic    o_full_stalled,
    output t_result o_res
);

    logic    r_valid, n_valid;
    t_result r_res;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_res <= i_res;
    end

    assign o_valid        = r_valid;
    assign o_full_stalled = r_valid && i_stall;
    assign o_res          = r_res;

endmodule

// File: src/sof_length_crc_frame_receiver_core.sv
// Start-of-frame / length / CRC-16 frame receiver.
// Input channel (i_in_valid, o_in_stall, i_data_byte) carries one received byte per transfer.
// The block hunts for the start byte, then takes command, type and a little-endian length,
// forwards each payload byte, and closes the frame on the second trailing CRC byte.
// Output channel (o_out_valid, i_out_stall, o_*) carries one result per transfer:
// a payload byte, frame good, bad CRC, or length too long. Header, start and CRC bytes
// that end nothing give no result.
// Latency: a result is presented on the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle while o_in_stall is low; the CRC-16/MCRF4XX byte update
// and the frame state machine logic are both combinational, ahead of the result register.
// Stall: while a result waits in the result register under i_out_stall, o_in_stall is
// raised; otherwise bytes are taken every cycle, including bytes that give no result.
// Configuration (i_cfg_we, i_cfg_index, i_cfg_data): 0 start byte, 1 maximum payload
// length (limited to MAX_PAYLOAD_BYTES), 2 valid type mask. Write only while idle.
// Reset (synchronous, i_rst_n low): hunt for start, CRC at all ones, output empty,
// start byte 0xAA, maximum length 256, type mask 0x1F.
module sof_length_crc_frame_receiver_core
    import slcfr_pkg::*;
#(
    parameter int MAX_PAYLOAD_BYTES = 256
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_payload_index,
    output logic [7:0]  o_command,
    output logic [7:0]  o_message_type,
    output logic        o_type_valid,
    output logic [15:0] o_payload_length,
    output logic [15:0] o_received_crc,
    output logic [15:0] o_computed_crc,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    t_cfg    r_cfg;
    logic    w_accept;
    logic    w_res_valid;
    t_result w_res;
    t_result w_out;
    logic    w_full_stalled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte  <= START_BYTE_RST;
            r_cfg.max_len     <= MAX_LEN_RST;
            r_cfg.type_enable <= TYPE_MASK_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_START_BYTE: r_cfg.start_byte  <= i_cfg_data[7:0];
                CFG_MAX_LEN:    r_cfg.max_len     <= i_cfg_data;
                CFG_TYPE_MASK:  r_cfg.type_enable <= i_cfg_data[7:0];
                default:        r_cfg             <= r_cfg;
            endcase
        end
    end

    assign o_in_stall = w_full_stalled;
    assign w_accept   = i_in_valid && !w_full_stalled;

    slcfr_parser #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data_byte (i_data_byte),
        .i_cfg       (r_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    slcfr_out_reg u_out_reg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_res_valid),
        .i_res          (w_res),
        .i_stall        (i_out_stall),
        .o_valid        (o_out_valid),
        .o_full_stalled (w_full_stalled),
        .o_res          (w_out)
    );

    assign o_kind           = w_out.kind;
    assign o_payload_byte   = w_out.payload_byte;
    assign o_payload_index  = w_out.payload_index;
    assign o_command        = w_out.command;
    assign o_message_type   = w_out.message_type;
    assign o_type_valid     = w_out.type_valid;
    assign o_payload_length = w_out.payload_length;
    assign o_received_crc   = w_out.trailer_crc;
    assign o_computed_crc   = w_out.computed_crc;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty result register");

    a_good_crc_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_GOOD) |-> (o_received_crc == o_computed_crc))
        else $error("frame good with mismatched CRC");

    a_bad_crc_mismatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_BAD_CRC) |-> (o_received_crc != o_computed_crc))
        else $error("bad CRC result with matching CRC");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_PAYLOAD) |->
            ({8'd0, o_payload_index} < o_payload_length))
        else $error("payload index beyond payload length");
`endif

endmodule
